[rtl/brss_pkg.sv]
// Package for the bigram record selection sorter: record type, sort key
// function and the read-only microcode table of the sequencer. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package brss_pkg;

  // One stored bigram record.
  typedef struct packed {
    logic [6:0]  c0;
    logic [6:0]  c1;
    logic [31:0] freq;
  } rec_t;

  // Sort modes.
  localparam logic [1:0] MODE_FREQ_ASC  = 2'd0;
  localparam logic [1:0] MODE_FREQ_DESC = 2'd1;

  // Sequencer step addresses.
  localparam int STEP_W = 3;
  localparam logic [STEP_W-1:0] STEP_IDLE = 3'd0;
  localparam logic [STEP_W-1:0] STEP_RD_I = 3'd1;
  localparam logic [STEP_W-1:0] STEP_CAP  = 3'd2;
  localparam logic [STEP_W-1:0] STEP_SCAN = 3'd3;
  localparam logic [STEP_W-1:0] STEP_EMIT = 3'd4;

  // Jump conditions.
  localparam logic [1:0] COND_NEXT = 2'd0;  // fall through to the next step
  localparam logic [1:0] COND_LAST = 2'd1;  // jump when a last record is taken
  localparam logic [1:0] COND_SCAN = 2'd2;  // repeat while records remain to read
  localparam logic [1:0] COND_EMIT = 2'd3;  // hold until the output is free

  typedef struct packed {
    logic              in_rdy;  // accept input requests
    logic              rd_j;    // read address is the scan index, else the pass index
    logic              ld_cur;  // capture the record at the pass index
    logic              scan;    // issue scan reads and compare returned records
    logic              emit;    // emit the pass winner and swap in memory
    logic [1:0]        cond;
    logic [STEP_W-1:0] target;
  } ctl_t;

  function automatic ctl_t ucode(input logic [STEP_W-1:0] step);
    ctl_t cw;
    cw = '{in_rdy: 1'b0, rd_j: 1'b0, ld_cur: 1'b0, scan: 1'b0, emit: 1'b0,
           cond: COND_NEXT, target: STEP_IDLE};
    case (step)
      STEP_IDLE: begin
        cw.in_rdy = 1'b1;
        cw.cond   = COND_LAST;
        cw.target = STEP_RD_I;
      end
      STEP_RD_I: begin
        cw.cond = COND_NEXT;
      end
      STEP_CAP: begin
        cw.ld_cur = 1'b1;
        cw.rd_j   = 1'b1;
        cw.scan   = 1'b1;
        cw.cond   = COND_NEXT;
      end
      STEP_SCAN: begin
        cw.rd_j = 1'b1;
        cw.scan = 1'b1;
        cw.cond = COND_SCAN;
      end
      STEP_EMIT: begin
        cw.emit   = 1'b1;
        cw.cond   = COND_EMIT;
        cw.target = STEP_RD_I;
      end
      default: begin
        cw.cond   = COND_NEXT;
        cw.target = STEP_IDLE;
      end
    endcase
    return cw;
  endfunction

  function automatic logic [6:0] fold_lower(input logic [6:0] c);
    if (c >= 7'h41 && c <= 7'h5A) begin
      return c + 7'h20;
    end
    return c;
  endfunction

  // Smaller key sorts first. Bit 1 of the mode selects the bigram key.
  function automatic logic [31:0] sort_key(input rec_t r, input logic [1:0] mode);
    logic [31:0] biased;
    biased = r.freq ^ 32'h8000_0000;
    if (mode[1]) begin
      return {18'd0, fold_lower(r.c0), fold_lower(r.c1)};
    end else if (mode == MODE_FREQ_DESC) begin
      return ~biased;
    end
    return biased;
  endfunction

endpackage

`default_nettype wire

[rtl/bigram_record_selection_sort_core.sv]
// Top level of the bigram record selection sorter: record memory, scan
// datapath and microcoded sequencer. Depends on brss_pkg.
`timescale 1ns / 1ps
`default_nettype none

// Records are loaded one per cycle into a single-port-write, registered-read
// memory of MAX_ENTRIES entries until a request with last_item set arrives;
// records beyond capacity are dropped. The set of N records is then sorted by
// selection with one comparator and one memory read port: a pass fetches the
// record at the pass index, captures it with the first scan read, issues the
// remaining scan reads, makes a final compare and emits the winner once the
// output is free. Each pass winner is emitted as soon as its pass ends, so
// results stream out during the sort.
// Input requests are refused during reset and from the last record of a set
// until the final result has been placed in the output register.
// sort_mode is used while sorting and may be written only while the block is
// idle: 0 frequency ascending, 1 frequency descending, 2 or 3 bigram
// ascending with A..Z folded to lower case. Ties keep selection-swap order.
module bigram_record_selection_sort_core #(
  parameter int MAX_ENTRIES = 64
) (
  input  wire                clk,
  input  wire                rst,
  input  wire                in_valid,
  output logic               in_ready,
  input  wire  [6:0]         first_char,
  input  wire  [6:0]         second_char,
  input  wire  signed [31:0] frequency,
  input  wire                last_item,
  output logic               out_valid,
  input  wire                out_ready,
  output logic [6:0]         out_first_char,
  output logic [6:0]         out_second_char,
  output logic signed [31:0] out_frequency,
  output logic               last_out,
  input  wire                cfg_we,
  input  wire  [1:0]         cfg_wdata
);

  localparam int IW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CW = $clog2(MAX_ENTRIES + 1);

  logic [1:0] sort_mode;

  // Sequencer.
  logic [brss_pkg::STEP_W-1:0] step;
  logic [brss_pkg::STEP_W-1:0] step_next;
  brss_pkg::ctl_t              cw;

  // Datapath registers.
  logic [CW-1:0]     fill;
  logic [IW-1:0]     i;
  logic [CW-1:0]     j;
  logic [IW-1:0]     loc;
  logic              pend;
  brss_pkg::rec_t    cur;
  brss_pkg::rec_t    best;

  // Memory.
  brss_pkg::rec_t    mem [MAX_ENTRIES];
  brss_pkg::rec_t    rd_data;
  logic [IW-1:0]     rd_addr;
  logic              mem_we;
  logic [IW-1:0]     mem_waddr;
  brss_pkg::rec_t    mem_wdata;

  logic              in_acc;
  logic              store_ok;
  logic              out_free;
  logic              issue;
  logic              i_last;
  logic              better;
  brss_pkg::rec_t    in_rec;

  assign cw       = brss_pkg::ucode(step);
  assign in_ready = cw.in_rdy && !rst;
  assign in_acc   = in_valid && in_ready;
  assign store_ok = fill < CW'(MAX_ENTRIES);
  assign out_free = !out_valid || out_ready;
  assign issue    = cw.scan && (j < fill);
  assign i_last   = (CW'(i) + CW'(1)) == fill;
  assign better   = brss_pkg::sort_key(rd_data, sort_mode)
                    < brss_pkg::sort_key(best, sort_mode);

  assign in_rec.c0   = first_char;
  assign in_rec.c1   = second_char;
  assign in_rec.freq = $unsigned(frequency);

  assign rd_addr = cw.rd_j ? j[IW-1:0] : i;

  // The write port loads records while idle and takes the swap write on emit.
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = fill[IW-1:0];
    mem_wdata = in_rec;
    if (in_acc && store_ok) begin
      mem_we = 1'b1;
    end else if (cw.emit && out_free) begin
      mem_we    = 1'b1;
      mem_waddr = loc;
      mem_wdata = cur;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_data <= mem[rd_addr];
  end

  always_comb begin
    step_next = step;
    case (cw.cond)
      brss_pkg::COND_NEXT: begin
        step_next = step + brss_pkg::STEP_W'(1);
      end
      brss_pkg::COND_LAST: begin
        if (in_acc && last_item) begin
          step_next = cw.target;
        end
      end
      brss_pkg::COND_SCAN: begin
        if (!(j < fill)) begin
          step_next = step + brss_pkg::STEP_W'(1);
        end
      end
      brss_pkg::COND_EMIT: begin
        if (out_free) begin
          step_next = i_last ? brss_pkg::STEP_IDLE : cw.target;
        end
      end
      default: begin
        step_next = brss_pkg::STEP_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step      <= brss_pkg::STEP_IDLE;
      sort_mode <= brss_pkg::MODE_FREQ_ASC;
      fill      <= '0;
      i         <= '0;
      j         <= '0;
      pend      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      step <= step_next;
      pend <= issue;
      if (cfg_we) begin
        sort_mode <= cfg_wdata;
      end
      if (in_acc && store_ok) begin
        fill <= fill + CW'(1);
      end
      if (step == brss_pkg::STEP_RD_I) begin
        j <= CW'(i) + CW'(1);
      end else if (issue) begin
        j <= j + CW'(1);
      end
      if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (cw.emit && out_free) begin
        out_valid <= 1'b1;
        if (i_last) begin
          i    <= '0;
          fill <= '0;
        end else begin
          i <= i + IW'(1);
        end
      end
    end
  end

  // Pass registers: the record at the pass index and the running winner.
  always_ff @(posedge clk) begin
    if (cw.ld_cur) begin
      cur  <= rd_data;
      best <= rd_data;
      loc  <= i;
    end else if (cw.scan && pend && better) begin
      // The returned record was read from the address just before j.
      best <= rd_data;
      loc  <= IW'(j - CW'(1));
    end
    if (cw.emit && out_free) begin
      out_first_char  <= best.c0;
      out_second_char <= best.c1;
      out_frequency   <= $signed(best.freq);
      last_out        <= i_last;
    end
  end

endmodule

`default_nettype wire

[rtl/brss_checker.sv]
// Port-level checker for the bigram record selection sorter and the bind that
// attaches it to bigram_record_selection_sort_core. No package dependencies.
`timescale 1ns / 1ps
`default_nettype none

module brss_checker (
  input wire        clk,
  input wire        rst,
  input wire        in_valid,
  input wire        in_ready,
  input wire        last_item,
  input wire        out_valid,
  input wire        out_ready,
  input wire [6:0]  out_first_char,
  input wire [6:0]  out_second_char,
  input wire [31:0] out_frequency,
  input wire        last_out
);

  // A stalled result keeps its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_first_char)
      && $stable(out_second_char) && $stable(out_frequency) && $stable(last_out))
    else $error("stalled result changed");

  // The last record of a set starts the sort, which refuses further requests.
  a_last_blocks: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && last_item |=> !in_ready)
    else $error("input still accepted after the last record");

  // Records that are not last keep the block collecting.
  a_collect: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && !last_item |=> in_ready)
    else $error("collection stopped without a last record");

  // No result is valid right after reset.
  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid right after reset");

endmodule

bind bigram_record_selection_sort_core brss_checker u_brss_checker (
  .clk             (clk),
  .rst             (rst),
  .in_valid        (in_valid),
  .in_ready        (in_ready),
  .last_item       (last_item),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .out_first_char  (out_first_char),
  .out_second_char (out_second_char),
  .out_frequency   (out_frequency),
  .last_out        (last_out)
);

`default_nettype wire

[tb/sorted_record_checker.sv]
// Checker for the bigram record selection sorter: watches the request,
// result and mode-write ports, predicts the sorted output and compares it.
// Depends on brss_pkg for the record type and the sort mode names.
`timescale 1ns / 1ps

module sorted_record_checker #(
  parameter int MAX_ENTRIES = 64
) (
  input  wire               clk,
  input  wire               rst,
  input  wire               in_valid,
  input  wire               in_ready,
  input  wire  [6:0]        first_char,
  input  wire  [6:0]        second_char,
  input  wire  [31:0]       frequency,
  input  wire               last_item,
  input  wire               out_valid,
  input  wire               out_ready,
  input  wire  [6:0]        out_first_char,
  input  wire  [6:0]        out_second_char,
  input  wire  [31:0]       out_frequency,
  input  wire               last_out,
  input  wire               cfg_we,
  input  wire  [1:0]        cfg_wdata,
  output int                mismatch_count,
  output int                results_pending
);

  typedef struct packed {
    brss_pkg::rec_t rec;
    logic           last;
  } sorted_rec_t;

  brss_pkg::rec_t collected [MAX_ENTRIES];
  int             collected_count = 0;
  logic [1:0]     order_mode = brss_pkg::MODE_FREQ_ASC;
  sorted_rec_t    sorted_queue [$];
  int             mismatch_total = 0;

  initial begin
    mismatch_count = 0;
    results_pending = 0;
  end

  task automatic report_mismatch(input string what);
    mismatch_total++;
    $display("%0t ns: mismatch: %s", $time, what);
  endtask

  function automatic logic [6:0] to_lower(input logic [6:0] c);
    return (c >= 7'h41 && c <= 7'h5A) ? (c | 7'h20) : c;
  endfunction

  // Unsigned ordering key; the smallest key is placed first. Flipping the sign
  // bit lets an unsigned comparison order signed frequencies.
  function automatic logic [31:0] order_key(input brss_pkg::rec_t r, input logic [1:0] mode);
    if (mode[1]) begin
      return {18'd0, to_lower(r.c0), to_lower(r.c1)};
    end else if (mode == brss_pkg::MODE_FREQ_DESC) begin
      return {r.freq[31], ~r.freq[30:0]};
    end
    return {~r.freq[31], r.freq[30:0]};
  endfunction

  // Selection sort over the collected records; the result stream is queued in
  // placement order.
  task automatic sort_collected();
    brss_pkg::rec_t swap_rec;
    logic [31:0]    best_key;
    logic [31:0]    probe_key;
    int             best_pos;
    for (int i = 0; i < collected_count; i++) begin
      best_pos = i;
      best_key = order_key(collected[i], order_mode);
      for (int j = i + 1; j < collected_count; j++) begin
        probe_key = order_key(collected[j], order_mode);
        if (probe_key < best_key) begin
          best_key = probe_key;
          best_pos = j;
        end
      end
      swap_rec = collected[i];
      collected[i] = collected[best_pos];
      collected[best_pos] = swap_rec;
      sorted_queue.push_back('{rec: collected[i], last: (i == collected_count - 1)});
    end
    collected_count = 0;
  endtask

  always @(posedge clk) begin
    sorted_rec_t want;
    if (rst) begin
      collected_count = 0;
      order_mode = brss_pkg::MODE_FREQ_ASC;
      sorted_queue.delete();
    end else begin
      if (cfg_we) begin
        order_mode = cfg_wdata;
      end
      if (out_valid && out_ready) begin
        if (sorted_queue.size() == 0) begin
          report_mismatch($sformatf("unexpected record %h %h %h last %b", out_first_char,
                                    out_second_char, out_frequency, last_out));
        end else begin
          want = sorted_queue.pop_front();
          if (out_first_char !== want.rec.c0) begin
            report_mismatch($sformatf("first char %h, expected %h", out_first_char, want.rec.c0));
          end
          if (out_second_char !== want.rec.c1) begin
            report_mismatch($sformatf("second char %h, expected %h", out_second_char,
                                      want.rec.c1));
          end
          if (out_frequency !== want.rec.freq) begin
            report_mismatch($sformatf("frequency %h, expected %h", out_frequency,
                                      want.rec.freq));
          end
          if (last_out !== want.last) begin
            report_mismatch($sformatf("last flag %b, expected %b", last_out, want.last));
          end
        end
      end
      if (in_valid && in_ready) begin
        // A record that arrives with the store full is dropped, but its last
        // flag still starts the sort.
        if (collected_count < MAX_ENTRIES) begin
          collected[collected_count] = '{c0: first_char, c1: second_char, freq: frequency};
          collected_count++;
        end
        if (last_item) begin
          sort_collected();
        end
      end
    end
    mismatch_count <= mismatch_total;
    results_pending <= sorted_queue.size();
  end

endmodule

[tb/tb_bigram_record_selection_sort_core.sv]
// Testbench top for the bigram record selection sorter: clock, reset, record
// and mode-write stimulus, receiver back-pressure and the verdict.
// Depends on brss_pkg, the sorter core and sorted_record_checker.
`timescale 1ns / 1ps

module tb_bigram_record_selection_sort_core;

  localparam int ENTRIES = 64;
  localparam int HOLD_CYCLES = 300;
  localparam int SETTLE_CYCLES = 16;
  localparam int DRAIN_LIMIT = 50000;
  localparam logic [1:0] MODE_BIGRAM = 2'd2;
  localparam logic [1:0] MODE_BIGRAM_ALT = 2'd3;

  logic        clk = 1'b0;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  logic [6:0]  first_char;
  logic [6:0]  second_char;
  logic [31:0] frequency;
  logic        last_item;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [6:0]  out_first_char;
  logic [6:0]  out_second_char;
  logic [31:0] out_frequency;
  logic        last_out;
  logic        cfg_we;
  logic [1:0]  cfg_wdata;

  int          tx_idle_pct = 0;
  int          rx_idle_pct = 0;
  logic        hold_toggle = 1'b0;
  logic        hold_seen = 1'b0;
  int          hold_left = 0;
  int          mismatch_count;
  int          results_pending;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  bigram_record_selection_sort_core #(
    .MAX_ENTRIES(ENTRIES)
  ) dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .first_char(first_char),
    .second_char(second_char),
    .frequency(frequency),
    .last_item(last_item),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_first_char(out_first_char),
    .out_second_char(out_second_char),
    .out_frequency(out_frequency),
    .last_out(last_out),
    .cfg_we(cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  sorted_record_checker #(
    .MAX_ENTRIES(ENTRIES)
  ) checker_i (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .first_char(first_char),
    .second_char(second_char),
    .frequency(frequency),
    .last_item(last_item),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_first_char(out_first_char),
    .out_second_char(out_second_char),
    .out_frequency(out_frequency),
    .last_out(last_out),
    .cfg_we(cfg_we),
    .cfg_wdata(cfg_wdata),
    .mismatch_count(mismatch_count),
    .results_pending(results_pending)
  );

  // Receiver: random stalls, plus a long hold-off whenever the stimulus flips
  // hold_toggle.
  always @(posedge clk) begin
    if (hold_toggle != hold_seen) begin
      hold_seen <= hold_toggle;
      hold_left <= HOLD_CYCLES;
      out_ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  task automatic offer_record(input logic [6:0] c0, input logic [6:0] c1,
                              input logic [31:0] freq, input logic last);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    first_char <= c0;
    second_char <= c1;
    frequency <= freq;
    last_item <= last;
    do @(posedge clk); while (!in_ready);
  endtask

  function automatic logic [6:0] random_char();
    case ($urandom_range(2))
      0: return 7'($urandom_range(127));
      1: return 7'($urandom_range(25)) + ($urandom_range(1) ? 7'h41 : 7'h61);
      // Two letters in both cases, so that folded keys tie often.
      default: return 7'h41 + 7'($urandom_range(1)) + ($urandom_range(1) ? 7'h20 : 7'h00);
    endcase
  endfunction

  function automatic brss_pkg::rec_t random_record();
    brss_pkg::rec_t r;
    case ($urandom_range(3))
      0: r.freq = 32'h8000_0000 + $urandom_range(2);
      1: r.freq = 32'h7FFF_FFFF - $urandom_range(2);
      2: r.freq = $urandom_range(6) - 3;
      default: r.freq = $urandom();
    endcase
    r.c0 = random_char();
    r.c1 = random_char();
    return r;
  endfunction

  task automatic offer_random_set(input int count);
    brss_pkg::rec_t r;
    for (int k = 0; k < count; k++) begin
      r = random_record();
      offer_record(r.c0, r.c1, r.freq, k == count - 1);
    end
  endtask

  // Drop the request line and wait for every sorted record to come back.
  task automatic close_set_and_drain();
    int waited;
    waited = 0;
    in_valid <= 1'b0;
    do begin
      @(posedge clk);
      waited++;
    end while (results_pending != 0 && waited < DRAIN_LIMIT);
  endtask

  // Wait with the block idle before the mode changes.
  task automatic write_sort_mode(input logic [1:0] mode);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_wdata <= mode;
    cfg_we <= 1'b1;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin
    int size;
    int phase_items;
    rst <= 1'b1;
    in_valid <= 1'b0;
    first_char <= 7'h00;
    second_char <= 7'h00;
    frequency <= 32'h0;
    last_item <= 1'b0;
    cfg_we <= 1'b0;
    cfg_wdata <= brss_pkg::MODE_FREQ_ASC;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    tx_idle_pct <= 6;
    rx_idle_pct <= 72;

    // Frequency ascending from reset: both extremes, minus one, zero, ties on
    // the minimum and on minus one, and characters at zero and 127.
    offer_record(7'h41, 7'h7F, 32'h7FFF_FFFF, 1'b0);
    offer_record(7'h00, 7'h01, 32'h8000_0000, 1'b0);
    offer_record(7'h7F, 7'h00, 32'hFFFF_FFFF, 1'b0);
    offer_record(7'h01, 7'h7F, 32'h0000_0000, 1'b0);
    offer_record(7'h2A, 7'h55, 32'hFFFF_FFFF, 1'b0);
    offer_record(7'h55, 7'h2A, 32'h8000_0000, 1'b1);
    close_set_and_drain();

    // Frequency descending: a set of one record, then a set with a tie.
    write_sort_mode(brss_pkg::MODE_FREQ_DESC);
    offer_record(7'h7F, 7'h7F, 32'h0000_0000, 1'b1);
    close_set_and_drain();
    offer_record(7'h10, 7'h20, 32'h0000_0005, 1'b0);
    offer_record(7'h11, 7'h21, 32'h7FFF_FFFF, 1'b0);
    offer_record(7'h12, 7'h22, 32'h0000_0005, 1'b0);
    offer_record(7'h13, 7'h23, 32'h8000_0000, 1'b1);
    close_set_and_drain();

    // Bigram order: case folding of A..Z only, so '[' and '@' stay put, and a
    // zero first character.
    write_sort_mode(MODE_BIGRAM);
    offer_record(7'h42, 7'h61, 32'd1, 1'b0);
    offer_record(7'h62, 7'h41, 32'd2, 1'b0);
    offer_record(7'h61, 7'h7A, 32'd3, 1'b0);
    offer_record(7'h5B, 7'h40, 32'd4, 1'b0);
    offer_record(7'h5A, 7'h40, 32'd5, 1'b0);
    offer_record(7'h00, 7'h7F, 32'd6, 1'b1);
    close_set_and_drain();

    // The undefined mode sorts by bigram as well; all four keys tie in pairs.
    write_sort_mode(MODE_BIGRAM_ALT);
    offer_record(7'h7A, 7'h5A, 32'd7, 1'b0);
    offer_record(7'h41, 7'h61, 32'd8, 1'b0);
    offer_record(7'h5A, 7'h7A, 32'd9, 1'b0);
    offer_record(7'h61, 7'h41, 32'd10, 1'b1);
    close_set_and_drain();

    // Small random sets under three idling patterns.
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          tx_idle_pct <= 6;
          rx_idle_pct <= 72;
        end
        1: begin
          tx_idle_pct <= 72;
          rx_idle_pct <= 6;
        end
        default: begin
          tx_idle_pct <= 0;
          rx_idle_pct <= 0;
        end
      endcase
      phase_items = 0;
      while (phase_items < 6) begin
        write_sort_mode(2'($urandom_range(3)));
        size = $urandom_range(1, 8);
        offer_random_set(size);
        close_set_and_drain();
        phase_items += size;
      end
    end

    // Overfill the store: the two records past capacity are dropped, and the
    // last of them still starts the sort. The receiver then holds off while
    // the next set is already being offered.
    write_sort_mode(brss_pkg::MODE_FREQ_DESC);
    offer_random_set(ENTRIES + 2);
    hold_toggle <= ~hold_toggle;
    offer_random_set(5);
    close_set_and_drain();

    write_sort_mode(brss_pkg::MODE_FREQ_ASC);
    offer_random_set(6);
    close_set_and_drain();

    repeat (64) @(posedge clk);
    if (mismatch_count == 0 && results_pending == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // Watchdog: ends the run as failed far beyond the slowest correct run.
  initial begin
    #4_000_000;
    $display("Verification failed");
    $finish;
  end

endmodule

[files.f]
rtl/brss_pkg.sv
rtl/bigram_record_selection_sort_core.sv
rtl/brss_checker.sv
tb/sorted_record_checker.sv
tb/tb_bigram_record_selection_sort_core.sv
